// ===== rtl/lru_mru_set_replacement_core_macros.svh =====
// ---------------------------------------------------------------------------
// lru_mru_set_replacement_core_macros
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef LRU_MRU_SET_REPLACEMENT_CORE_MACROS_SVH
`define LRU_MRU_SET_REPLACEMENT_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define LRUM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lrum assertion failed");

// implication checked at every clock edge outside reset
`define LRUM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrum implication failed");

`endif

// ===== rtl/lrum_pkg.sv =====
// ---------------------------------------------------------------------------
// lrum_pkg
// shared types and constants of the lru/mru set replacement core
// ---------------------------------------------------------------------------
package lrum_pkg;

   localparam int KEY_W       = 64;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 5;
   localparam int LIMIT_W     = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_REPLACE_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WAYS_IN_USE  = 8'd1;

   localparam logic MODE_LRU = 1'b0;
   localparam logic MODE_MRU = 1'b1;

   localparam logic [LIMIT_W-1:0] WAYS_IN_USE_RESET = 5'd16;

   typedef struct packed {
      logic load;
      logic lookup;
      logic update;
      logic cfg_write;
   } lrum_cmd_type;

endpackage

// ===== rtl/lrum_ctrl.sv =====
// ---------------------------------------------------------------------------
// lrum_ctrl
// sequencer: idle, lookup, update; issues datapath commands
// ---------------------------------------------------------------------------
module lrum_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  csr_valid,
   output logic                  busy,
   output lrum_pkg::lrum_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.load      = start && (state_ff == ST_IDLE);
   assign cmd.lookup    = (state_ff == ST_LOOKUP);
   assign cmd.update    = (state_ff == ST_UPDATE);
   assign cmd.cfg_write = csr_valid && (state_ff == ST_IDLE);

endmodule

// ===== rtl/lrum_dp.sv =====
// ---------------------------------------------------------------------------
// lrum_dp
// tag cells, recency ranks, counters, config registers and result register
// ---------------------------------------------------------------------------
module lrum_dp #(
   parameter int WAYS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lrum_pkg::lrum_cmd_type                cmd,
   input  logic [lrum_pkg::KEY_W-1:0]            key_tag,
   input  logic [lrum_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrum_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_evicted,
   output logic [lrum_pkg::KEY_W-1:0]            rsp_victim_tag,
   output logic [lrum_pkg::COUNT_W-1:0]          rsp_access_total,
   output logic [lrum_pkg::COUNT_W-1:0]          rsp_miss_total
);

   localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W = $clog2(WAYS + 1);
   localparam int CMP_W = (CNT_W > lrum_pkg::LIMIT_W) ? CNT_W : lrum_pkg::LIMIT_W;
   localparam int KEY_W = lrum_pkg::KEY_W;
   localparam int CW    = lrum_pkg::COUNT_W;

   // config
   logic                          mode_ff;
   logic [lrum_pkg::LIMIT_W-1:0]  wiu_ff;

   // entry cells
   logic [KEY_W-1:0] tag_ff   [WAYS];
   logic [AGE_W-1:0] age_ff   [WAYS];
   logic [AGE_W-1:0] age_in   [WAYS];
   logic [WAYS-1:0]  valid_ff;
   logic [WAYS-1:0]  valid_in;
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [CW-1:0]    acc_ff;
   logic [CW-1:0]    acc_in;
   logic [CW-1:0]    miss_ff;
   logic [CW-1:0]    miss_in;

   // lookup stage registers
   logic [KEY_W-1:0] key_ff;
   logic [WAYS-1:0]  hit_oh_ff;
   logic             hit_ff;
   logic [WAYS-1:0]  vic_oh_ff;
   logic             evict_ff;
   logic [WAYS-1:0]  slot_oh_ff;
   logic [AGE_W-1:0] found_age_ff;
   logic [AGE_W-1:0] vic_age_ff;
   logic [KEY_W-1:0] vic_tag_ff;

   // result registers
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic             rsp_evicted_ff;
   logic [KEY_W-1:0] rsp_victim_tag_ff;
   logic [CW-1:0]    rsp_access_ff;
   logic [CW-1:0]    rsp_miss_ff;

   // lookup stage logic
   logic [WAYS-1:0]  hit_oh;
   logic             hit_any;
   logic [CMP_W-1:0] lim;
   logic [CMP_W-1:0] occ_ext;
   logic [CMP_W-1:0] wiu_ext;
   logic             evict_need;
   logic [AGE_W-1:0] vic_age;
   logic [WAYS-1:0]  vic_oh;
   logic [WAYS-1:0]  free_vec;
   logic [WAYS-1:0]  slot_oh;
   logic [AGE_W-1:0] found_age;
   logic [KEY_W-1:0] vic_tag;

   assign occ_ext = CMP_W'(occ_ff);
   assign wiu_ext = CMP_W'(wiu_ff);

   always_comb begin
      lim = wiu_ext;
      if (wiu_ff == '0) lim = CMP_W'(1);
      if (wiu_ext > CMP_W'(WAYS)) lim = CMP_W'(WAYS);
   end

   genvar gi;
   generate
      for (gi = 0; gi < WAYS; gi++) begin : g_cmp
         assign hit_oh[gi] = valid_ff[gi] && (tag_ff[gi] == key_ff);
         assign vic_oh[gi] = evict_need && valid_ff[gi] && (age_ff[gi] == vic_age);
      end
   endgenerate

   assign hit_any    = |hit_oh;
   assign evict_need = !hit_any && (occ_ext >= lim) && (occ_ff != '0);
   assign vic_age    = (mode_ff == lrum_pkg::MODE_MRU) ? '0 : AGE_W'(occ_ff - CNT_W'(1));
   assign free_vec   = ~valid_ff | vic_oh;
   assign slot_oh    = free_vec & (~free_vec + WAYS'(1));

   always_comb begin
      found_age = '0;
      vic_tag   = '0;
      for (int i = 0; i < WAYS; i++) begin
         found_age = found_age | (age_ff[i] & {AGE_W{hit_oh[i]}});
         vic_tag   = vic_tag | (tag_ff[i] & {KEY_W{vic_oh[i]}});
      end
   end

   // update stage logic
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         age_in[i]   = age_ff[i];
         valid_in[i] = valid_ff[i];
         if (hit_ff) begin
            if (hit_oh_ff[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < found_age_ff)) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end else if (slot_oh_ff[i]) begin
            valid_in[i] = 1'b1;
            age_in[i]   = '0;
         end else if (vic_oh_ff[i]) begin
            valid_in[i] = 1'b0;
            age_in[i]   = '0;
         end else if (valid_ff[i]) begin
            if (evict_ff && (age_ff[i] > vic_age_ff)) begin
               age_in[i] = age_ff[i];
            end else begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   assign occ_in  = occ_ff + CNT_W'(!hit_ff && !evict_ff);
   assign acc_in  = acc_ff + CW'(1);
   assign miss_in = miss_ff + CW'(!hit_ff);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lrum_pkg::MODE_LRU;
         wiu_ff       <= lrum_pkg::WAYS_IN_USE_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         acc_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.cfg_write) begin
            unique case (csr_index)
               lrum_pkg::REG_REPLACE_MODE: mode_ff <= csr_wdata[0];
               lrum_pkg::REG_WAYS_IN_USE:  wiu_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.update) begin
            valid_ff <= valid_in;
            occ_ff   <= occ_in;
            acc_ff   <= acc_in;
            miss_ff  <= miss_in;
            for (int i = 0; i < WAYS; i++) begin
               age_ff[i] <= age_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_tag;
      end
      if (cmd.lookup) begin
         hit_oh_ff    <= hit_oh;
         hit_ff       <= hit_any;
         vic_oh_ff    <= vic_oh;
         evict_ff     <= evict_need;
         slot_oh_ff   <= slot_oh;
         found_age_ff <= found_age;
         vic_age_ff   <= vic_age;
         vic_tag_ff   <= vic_tag;
      end
      if (cmd.update) begin
         for (int i = 0; i < WAYS; i++) begin
            if (!hit_ff && slot_oh_ff[i]) tag_ff[i] <= key_ff;
         end
         rsp_hit_ff        <= hit_ff;
         rsp_evicted_ff    <= evict_ff;
         rsp_victim_tag_ff <= vic_tag_ff;
         rsp_access_ff     <= acc_in;
         rsp_miss_ff       <= miss_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_victim_tag   = rsp_victim_tag_ff;
   assign rsp_access_total = rsp_access_ff;
   assign rsp_miss_total   = rsp_miss_ff;

endmodule

// ===== rtl/lru_mru_set_replacement_core.sv =====
// ---------------------------------------------------------------------------
// lru_mru_set_replacement_core
// one fully associative set with lru or mru replacement
// ---------------------------------------------------------------------------
// usage:
//   request: drive req_key_tag and raise start; the transaction is taken at
//   a rising edge with start high and busy low.
//   response: rsp_valid pulses for one cycle with hit, evicted, victim tag
//   and the running access and miss totals; the receiver cannot stall, so
//   the result must be captured in that cycle.
//   config: csr_valid/csr_ready write channel, csr_index 0 = replace mode,
//   1 = ways in use; other indexes are dropped. csr_ready is high while idle.
// sequence:
//   the accepting cycle is followed by a lookup state (parallel tag compare,
//   victim and free slot select) and an update state (rank, tag and counter
//   write), during which busy is high and no new request is taken; rsp_valid
//   rises once the update state is written, and the next request may already
//   be accepted at the edge at which the result is taken.
// reset:
//   synchronous; clears all valid bits, ranks, counters and the result
//   strobe, sets lru mode and ways in use 16. no clearing pass is needed.
// ---------------------------------------------------------------------------
module lru_mru_set_replacement_core #(
   parameter int WAYS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lrum_pkg::KEY_W-1:0]            req_key_tag,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_evicted,
   output logic [lrum_pkg::KEY_W-1:0]            rsp_victim_tag,
   output logic [lrum_pkg::COUNT_W-1:0]          rsp_access_total,
   output logic [lrum_pkg::COUNT_W-1:0]          rsp_miss_total,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lrum_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrum_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   lrum_pkg::lrum_cmd_type cmd;

   lrum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .cmd       (cmd)
   );

   lrum_dp #(
      .WAYS (WAYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .key_tag          (req_key_tag),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total)
   );

   assign csr_ready = !busy;

endmodule

// ===== rtl/lrum_checker.sv =====
// ---------------------------------------------------------------------------
// lrum_checker
// port level checks of the set replacement core
// ---------------------------------------------------------------------------
`include "lru_mru_set_replacement_core_macros.svh"

module lrum_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic                               rsp_hit,
   input logic                               rsp_evicted,
   input logic [lrum_pkg::KEY_W-1:0]         rsp_victim_tag
);

   `LRUM_ASSERT_IMP(a_accept_busy, clock, reset, start && !busy, ##1 busy)
   `LRUM_ASSERT_IMP(a_accept_rsp, clock, reset, start && !busy, ##3 rsp_valid)
   `LRUM_ASSERT(a_rsp_idle, clock, reset, !(rsp_valid && busy))
   `LRUM_ASSERT(a_hit_no_evict, clock, reset, !(rsp_valid && rsp_hit && rsp_evicted))
   `LRUM_ASSERT_IMP(a_victim_zero, clock, reset, rsp_valid && !rsp_evicted, rsp_victim_tag == '0)

endmodule

bind lru_mru_set_replacement_core lrum_checker u_lrum_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_evicted    (rsp_evicted),
   .rsp_victim_tag (rsp_victim_tag)
);

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the lru/mru set replacement core
// ---------------------------------------------------------------------------
// a directed table walks reset defaults, both key extremes, both replacement
// modes, limits of zero, one and above the set size, a limit dropped below
// the occupancy and writes to unused register indexes. random phases follow,
// each with its own mode, limit and request spacing, drawing keys mostly
// from a small pool so that hits, fills and evictions all occur. a local
// model of the set predicts each response; directed rows may carry a typed
// result instead. responses are checked field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int KEY_W           = lrum_pkg::KEY_W;
   localparam int COUNT_W         = lrum_pkg::COUNT_W;
   localparam int CSR_INDEX_W     = lrum_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W      = lrum_pkg::CSR_DATA_W;
   localparam int LIMIT_W         = lrum_pkg::LIMIT_W;
   localparam int WAYS            = 16;
   localparam int DIR_ROWS        = 25;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 192;
   localparam int POOL_MAX        = 40;
   localparam int RECENT_DEPTH    = 8;
   localparam int MAX_GAP         = 40;
   localparam int DRAIN_CYCLES    = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST   = 8'hFF;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic [KEY_W-1:0]   victim_tag;
      logic [COUNT_W-1:0] access_total;
      logic [COUNT_W-1:0] miss_total;
   } access_result_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [KEY_W-1:0]       key;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_data;
      logic                   typed;
      access_result_type      want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [KEY_W-1:0]       req_key_tag = '0;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic                   rsp_evicted;
   logic [KEY_W-1:0]       rsp_victim_tag;
   logic [COUNT_W-1:0]     rsp_access_total;
   logic [COUNT_W-1:0]     rsp_miss_total;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // set model state
   logic [KEY_W-1:0]   way_tag   [WAYS];
   bit                 way_valid [WAYS];
   int                 way_rank  [WAYS];
   logic [COUNT_W-1:0] access_count;
   logic [COUNT_W-1:0] miss_count;
   logic               mode_sel;
   logic [LIMIT_W-1:0] ways_setting;

   access_result_type pending_results[$];
   access_result_type oldest;
   logic [KEY_W-1:0] recent_keys[$];
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   dir_row_type directed [DIR_ROWS];
   int fail_count = 0;

   lru_mru_set_replacement_core #(.WAYS(WAYS)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_tag     (req_key_tag),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_victim_tag  (rsp_victim_tag),
      .rsp_access_total(rsp_access_total),
      .rsp_miss_total  (rsp_miss_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int active_limit();
      int lim;
      lim = int'(ways_setting);
      if (lim == 0) lim = 1;
      if (lim > WAYS) lim = WAYS;
      return lim;
   endfunction

   function automatic access_result_type predict_access(input logic [KEY_W-1:0] key);
      access_result_type r;
      int found;
      int occupied;
      int victim;
      int free_slot;
      int vrank;
      r = '0;
      found = -1;
      occupied = 0;
      victim = -1;
      free_slot = -1;
      for (int i = 0; i < WAYS; i++) begin
         if (way_valid[i]) begin
            occupied++;
            if (found < 0 && way_tag[i] == key) found = i;
         end
      end
      access_count = access_count + 1;
      if (found >= 0) begin
         vrank = way_rank[found];
         for (int i = 0; i < WAYS; i++)
            if (way_valid[i] && way_rank[i] < vrank) way_rank[i]++;
         way_rank[found] = 0;
      end else begin
         miss_count = miss_count + 1;
         if (occupied >= active_limit() && occupied > 0) begin
            for (int i = 0; i < WAYS; i++) begin
               if (!way_valid[i]) continue;
               if (victim < 0) begin
                  victim = i;
                  continue;
               end
               if (mode_sel == lrum_pkg::MODE_LRU ? way_rank[i] > way_rank[victim]
                                                  : way_rank[i] < way_rank[victim])
                  victim = i;
            end
            if (victim >= 0) begin
               vrank = way_rank[victim];
               r.evicted = 1'b1;
               r.victim_tag = way_tag[victim];
               way_valid[victim] = 1'b0;
               way_rank[victim] = 0;
               for (int i = 0; i < WAYS; i++)
                  if (way_valid[i] && way_rank[i] > vrank) way_rank[i]--;
            end
         end
         for (int i = 0; i < WAYS; i++) begin
            if (way_valid[i]) way_rank[i]++;
            else if (free_slot < 0) free_slot = i;
         end
         if (free_slot >= 0) begin
            way_valid[free_slot] = 1'b1;
            way_tag[free_slot] = key;
            way_rank[free_slot] = 0;
         end
      end
      r.hit = (found >= 0);
      r.access_total = access_count;
      r.miss_total = miss_count;
      return r;
   endfunction

   // one access transaction, optionally preceded by idle cycles
   task automatic send_access(input logic [KEY_W-1:0] key, input int idle_pct,
                              input bit typed, input access_result_type typed_result);
      int gap;
      access_result_type r;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && gap < MAX_GAP) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_key_tag <= key;
      do @(posedge clock); while (busy !== 1'b0);
      r = predict_access(key);
      pending_results.push_back(typed ? typed_result : r);
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
   endtask

   task automatic settle_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (last) csr_valid <= 1'b0;
      if (idx == lrum_pkg::REG_REPLACE_MODE) mode_sel = data[0];
      else if (idx == lrum_pkg::REG_WAYS_IN_USE) ways_setting = data;
   endtask

   task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: response with nothing pending, actual hit %b victim %h",
                     $time, rsp_hit, rsp_victim_tag);
         end else begin
            oldest = pending_results.pop_front();
            check_field("hit", KEY_W'(oldest.hit), KEY_W'(rsp_hit));
            check_field("evicted", KEY_W'(oldest.evicted), KEY_W'(rsp_evicted));
            check_field("victim_tag", oldest.victim_tag, rsp_victim_tag);
            check_field("access_total", KEY_W'(oldest.access_total),
                        KEY_W'(rsp_access_total));
            check_field("miss_total", KEY_W'(oldest.miss_total),
                        KEY_W'(rsp_miss_total));
         end
      end
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [KEY_W-1:0] key;
      logic [CSR_DATA_W-1:0] data;
      logic new_mode;
      logic [LIMIT_W-1:0] new_ways;
      int idle_pct;
      int pool_size;
      int sel;

      directed[0]  = '{ROW_ACCESS, 64'h0, 8'd0, 5'd0, 1'b1,
                       '{1'b0, 1'b0, 64'h0, 32'd1, 32'd1}};
      directed[1]  = '{ROW_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 5'd0, 1'b1,
                       '{1'b0, 1'b0, 64'h0, 32'd2, 32'd2}};
      directed[2]  = '{ROW_ACCESS, 64'h0, 8'd0, 5'd0, 1'b1,
                       '{1'b1, 1'b0, 64'h0, 32'd3, 32'd2}};
      directed[3]  = '{ROW_CSR, 64'h0, lrum_pkg::REG_WAYS_IN_USE, 5'd1, 1'b0, '0};
      // limit now below occupancy
      directed[4]  = '{ROW_ACCESS, 64'h5555_5555_5555_5555, 8'd0, 5'd0, 1'b1,
                       '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4, 32'd3}};
      directed[5]  = '{ROW_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0, 5'd0, 1'b1,
                       '{1'b0, 1'b1, 64'h0, 32'd5, 32'd4}};
      directed[6]  = '{ROW_CSR, 64'h0, lrum_pkg::REG_REPLACE_MODE, 5'd1, 1'b0, '0};
      directed[7]  = '{ROW_ACCESS, 64'h0123_4567_89AB_CDEF, 8'd0, 5'd0, 1'b0, '0};
      directed[8]  = '{ROW_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0, 5'd0, 1'b0, '0};
      directed[9]  = '{ROW_CSR, 64'h0, lrum_pkg::REG_WAYS_IN_USE, 5'd0, 1'b0, '0};
      directed[10] = '{ROW_ACCESS, 64'hFEDC_BA98_7654_3210, 8'd0, 5'd0, 1'b0, '0};
      directed[11] = '{ROW_ACCESS, 64'hFEDC_BA98_7654_3210, 8'd0, 5'd0, 1'b0, '0};
      directed[12] = '{ROW_CSR, 64'h0, lrum_pkg::REG_WAYS_IN_USE, 5'd31, 1'b0, '0};
      directed[13] = '{ROW_CSR, 64'h0, REG_UNUSED, 5'd31, 1'b0, '0};
      directed[14] = '{ROW_CSR, 64'h0, REG_LAST, 5'd0, 1'b0, '0};
      directed[15] = '{ROW_ACCESS, 64'h8000_0000_0000_0000, 8'd0, 5'd0, 1'b0, '0};
      directed[16] = '{ROW_ACCESS, 64'h0000_0000_0000_0001, 8'd0, 5'd0, 1'b0, '0};
      directed[17] = '{ROW_ACCESS, 64'h0, 8'd0, 5'd0, 1'b0, '0};
      directed[18] = '{ROW_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 5'd0, 1'b0, '0};
      directed[19] = '{ROW_ACCESS, 64'h8000_0000_0000_0000, 8'd0, 5'd0, 1'b0, '0};
      // only bit 0 of the mode data counts
      directed[20] = '{ROW_CSR, 64'h0, lrum_pkg::REG_REPLACE_MODE, 5'd2, 1'b0, '0};
      directed[21] = '{ROW_CSR, 64'h0, lrum_pkg::REG_WAYS_IN_USE, 5'd16, 1'b0, '0};
      directed[22] = '{ROW_ACCESS, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 5'd0, 1'b0, '0};
      directed[23] = '{ROW_ACCESS, 64'h0000_0000_0000_0001, 8'd0, 5'd0, 1'b0, '0};
      directed[24] = '{ROW_ACCESS, 64'h5555_5555_5555_5555, 8'd0, 5'd0, 1'b0, '0};

      for (int i = 0; i < WAYS; i++) begin
         way_tag[i] = '0;
         way_valid[i] = 1'b0;
         way_rank[i] = 0;
      end
      access_count = '0;
      miss_count = '0;
      mode_sel = lrum_pkg::MODE_LRU;
      ways_setting = lrum_pkg::WAYS_IN_USE_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed[i].kind == ROW_CSR) begin
            if (i == 0 || directed[i-1].kind != ROW_CSR) settle_idle();
            csr_write(directed[i].csr_idx, directed[i].csr_data,
                      i == DIR_ROWS - 1 || directed[i+1].kind != ROW_CSR);
         end else begin
            send_access(directed[i].key, 0, directed[i].typed, directed[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin new_mode = lrum_pkg::MODE_LRU; new_ways = 5'd16; idle_pct = 0;  end
            1: begin new_mode = lrum_pkg::MODE_MRU; new_ways = 5'd16; idle_pct = 79; end
            2: begin new_mode = lrum_pkg::MODE_LRU; new_ways = 5'd1;  idle_pct = 20; end
            3: begin new_mode = lrum_pkg::MODE_MRU; new_ways = 5'd0;  idle_pct = 0;  end
            4: begin new_mode = lrum_pkg::MODE_LRU; new_ways = 5'd31; idle_pct = 79; end
            5: begin new_mode = lrum_pkg::MODE_MRU; new_ways = 5'd4;  idle_pct = 20; end
            6: begin
               new_mode = lrum_pkg::MODE_LRU;
               new_ways = LIMIT_W'($urandom_range(2, 15));
               idle_pct = 0;
            end
            default: begin
               new_mode = ($urandom_range(0, 1) == 0) ? lrum_pkg::MODE_LRU
                                                      : lrum_pkg::MODE_MRU;
               new_ways = LIMIT_W'($urandom_range(0, 31));
               idle_pct = 20;
            end
         endcase
         settle_idle();
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_INDEX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom), 1'b0);
         data = CSR_DATA_W'($urandom);
         data[0] = new_mode;
         csr_write(lrum_pkg::REG_REPLACE_MODE, data, 1'b0);
         csr_write(lrum_pkg::REG_WAYS_IN_USE, new_ways, 1'b1);

         pool_size = active_limit() + $urandom_range(0, active_limit() + 3);
         if (pool_size > POOL_MAX) pool_size = POOL_MAX;
         for (int k = 0; k < pool_size; k++) key_pool[k] = {$urandom, $urandom};

         for (int j = 0; j < PHASE_ITEMS; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
               key = key_pool[$urandom_range(0, pool_size - 1)];
            else if (sel < 85 && recent_keys.size() > 0)
               key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else if (sel < 88)
               key = ($urandom_range(0, 1) == 0) ? '0 : '1;
            else
               key = {$urandom, $urandom};
            // bursts with no idling inside idle phases
            send_access(key, (j % 64 < 16) ? 0 : idle_pct, 1'b0, '0);
         end
      end

      settle_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
